// File: hw/rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen
`define CHK_NEVER(label, clk, rst, cond, msg) \
  `CHK_ASSERT(label, clk, rst, !(cond), msg)

`endif

// File: hw/rtl/i2crm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_pkg
// Types and constants of the I2C register transaction master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  localparam int DELAY_W = 18;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_TICKS_PER_US   = 2'd1
  } cfg_index_t;

  localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'h80;
  localparam logic [15:0] TICKS_PER_US_RESET   = 16'd72;
  localparam logic [7:0]  READ_BIT             = 8'h01;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] register_address;
    logic [7:0] write_byte;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_failed;
  } out_item_t;

  typedef enum logic [18:0] {
    PH_IDLE    = 19'd1 << 0,
    PH_S_SDA   = 19'd1 << 1,
    PH_S_SCL   = 19'd1 << 2,
    PH_S_FALL  = 19'd1 << 3,
    PH_S_CLAMP = 19'd1 << 4,
    PH_B_DATA  = 19'd1 << 5,
    PH_B_HIGH  = 19'd1 << 6,
    PH_B_LOW   = 19'd1 << 7,
    PH_A_REL   = 19'd1 << 8,
    PH_A_HIGH  = 19'd1 << 9,
    PH_A_LOW   = 19'd1 << 10,
    PH_R_LOW   = 19'd1 << 11,
    PH_R_HIGH  = 19'd1 << 12,
    PH_N_SET   = 19'd1 << 13,
    PH_N_HIGH  = 19'd1 << 14,
    PH_N_LOW   = 19'd1 << 15,
    PH_P_LOW   = 19'd1 << 16,
    PH_P_SCL   = 19'd1 << 17,
    PH_P_SDA   = 19'd1 << 18
  } phase_t;

  // hold time of each phase in microsecond units
  function automatic logic [2:0] hold_units(input phase_t p);
    logic [2:0] u;
    case (p)
      PH_S_SCL, PH_S_FALL, PH_P_LOW, PH_P_SDA: u = 3'd4;
      PH_B_DATA, PH_B_HIGH, PH_B_LOW, PH_R_LOW, PH_N_SET, PH_N_HIGH: u = 3'd2;
      PH_A_REL, PH_A_HIGH, PH_R_HIGH: u = 3'd1;
      default: u = 3'd0;
    endcase
    return u;
  endfunction

endpackage

// File: hw/rtl/i2crm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_seq
// Bus sequencer: advances the transaction state by one tick per step and
// presents the line levels and status that follow from it.
// ----------------------------------------------------------------------------
module i2crm_seq #(
  parameter int ACK_POLL_LIMIT = 250
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  i2crm_pkg::in_item_t   item,
  input  logic [7:0]            dev_addr,
  input  logic [15:0]           tpu,
  output i2crm_pkg::out_item_t  result
);
  import i2crm_pkg::*;

  phase_t              phase, phase_next;
  logic                is_read, is_read_next;
  logic [2:0]          byte_index, byte_index_next;
  logic [3:0]          bit_count, bit_count_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [7:0]          held_register, held_register_next;
  logic [7:0]          held_data, held_data_next;
  logic [DELAY_W-1:0]  delay_count, delay_count_next;
  logic [7:0]          poll_count, poll_count_next;
  logic [7:0]          received_byte, received_byte_next;
  logic                fail_flag, fail_flag_next;
  logic                line_scl, line_scl_next;
  logic                line_sda, line_sda_next;
  logic                line_oe, line_oe_next;

  logic                do_enter;
  phase_t              target;
  logic                load_byte;
  logic [2:0]          sel_idx;
  logic                done;
  logic [3:0]          bit_inc;

  localparam logic [7:0] POLL_LIMIT = 8'(ACK_POLL_LIMIT);

  function automatic logic [7:0] pick_byte(input logic [2:0] idx, input logic rd,
                                           input logic [7:0] dev, input logic [7:0] reg_a,
                                           input logic [7:0] dat);
    logic [7:0] b;
    if (idx == 3'd0) begin
      b = dev;
    end else if (idx == 3'd1) begin
      b = reg_a;
    end else if (rd) begin
      b = dev | READ_BIT;
    end else begin
      b = dat;
    end
    return b;
  endfunction

  function automatic logic [DELAY_W-1:0] hold_ticks(input phase_t p, input logic [15:0] t);
    logic [DELAY_W-1:0] prod;
    case (hold_units(p))
      3'd1:    prod = {2'b00, t};
      3'd2:    prod = {1'b0, t, 1'b0};
      3'd4:    prod = {t, 2'b00};
      default: prod = '0;
    endcase
    // a zero hold still lasts one tick
    if (prod == '0) begin
      prod = DELAY_W'(1);
    end
    return prod;
  endfunction

  always_comb begin
    phase_next         = phase;
    is_read_next       = is_read;
    byte_index_next    = byte_index;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    held_register_next = held_register;
    held_data_next     = held_data;
    delay_count_next   = delay_count;
    poll_count_next    = poll_count;
    received_byte_next = received_byte;
    fail_flag_next     = fail_flag;
    line_scl_next      = line_scl;
    line_sda_next      = line_sda;
    line_oe_next       = line_oe;
    do_enter           = 1'b0;
    target             = PH_IDLE;
    load_byte          = 1'b0;
    sel_idx            = byte_index;
    done               = 1'b0;
    bit_inc            = bit_count + 4'd1;

    if (phase == PH_IDLE) begin
      if (item.kind == KIND_WRITE || item.kind == KIND_READ) begin
        is_read_next       = (item.kind == KIND_READ);
        held_register_next = item.register_address;
        held_data_next     = item.write_byte;
        byte_index_next    = 3'd0;
        bit_count_next     = 4'd0;
        shift_byte_next    = 8'd0;
        poll_count_next    = 8'd0;
        fail_flag_next     = 1'b0;
        do_enter           = 1'b1;
        target             = PH_S_SDA;
      end
    end else if (delay_count > DELAY_W'(1)) begin
      delay_count_next = delay_count - DELAY_W'(1);
    end else begin
      case (phase)
        PH_S_SDA: begin
          do_enter = 1'b1;
          target   = PH_S_SCL;
        end
        PH_S_SCL: begin
          do_enter = 1'b1;
          target   = PH_S_FALL;
        end
        PH_S_FALL: begin
          do_enter = 1'b1;
          target   = PH_S_CLAMP;
        end
        PH_S_CLAMP: begin
          load_byte = 1'b1;
        end
        PH_B_DATA: begin
          do_enter = 1'b1;
          target   = PH_B_HIGH;
        end
        PH_B_HIGH: begin
          do_enter = 1'b1;
          target   = PH_B_LOW;
        end
        PH_B_LOW: begin
          bit_count_next = bit_inc;
          do_enter       = 1'b1;
          if (bit_inc >= 4'd8) begin
            poll_count_next = 8'd0;
            target          = PH_A_REL;
          end else begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            target          = PH_B_DATA;
          end
        end
        PH_A_REL: begin
          do_enter = 1'b1;
          target   = PH_A_HIGH;
        end
        PH_A_HIGH: begin
          if (!item.sda_sample) begin
            do_enter = 1'b1;
            target   = PH_A_LOW;
          end else if (poll_count >= POLL_LIMIT) begin
            // no acknowledge in time: abort with stop
            fail_flag_next = 1'b1;
            do_enter       = 1'b1;
            target         = PH_P_LOW;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end
        PH_A_LOW: begin
          byte_index_next = byte_index + 3'd1;
          sel_idx         = byte_index + 3'd1;
          if (!is_read) begin
            if (sel_idx < 3'd3) begin
              load_byte = 1'b1;
            end else begin
              do_enter = 1'b1;
              target   = PH_P_LOW;
            end
          end else if (sel_idx == 3'd1) begin
            load_byte = 1'b1;
          end else if (sel_idx == 3'd2) begin
            // repeated start before the read address
            do_enter = 1'b1;
            target   = PH_S_SDA;
          end else begin
            bit_count_next  = 4'd0;
            shift_byte_next = 8'd0;
            do_enter        = 1'b1;
            target          = PH_R_LOW;
          end
        end
        PH_R_LOW: begin
          shift_byte_next = {shift_byte[6:0], item.sda_sample};
          do_enter        = 1'b1;
          target          = PH_R_HIGH;
        end
        PH_R_HIGH: begin
          bit_count_next = bit_inc;
          do_enter       = 1'b1;
          if (bit_inc >= 4'd8) begin
            received_byte_next = shift_byte;
            target             = PH_N_SET;
          end else begin
            target = PH_R_LOW;
          end
        end
        PH_N_SET: begin
          do_enter = 1'b1;
          target   = PH_N_HIGH;
        end
        PH_N_HIGH: begin
          do_enter = 1'b1;
          target   = PH_N_LOW;
        end
        PH_N_LOW: begin
          do_enter = 1'b1;
          target   = PH_P_LOW;
        end
        PH_P_LOW: begin
          do_enter = 1'b1;
          target   = PH_P_SCL;
        end
        PH_P_SCL: begin
          do_enter = 1'b1;
          target   = PH_P_SDA;
        end
        PH_P_SDA: begin
          phase_next       = PH_IDLE;
          delay_count_next = '0;
          done             = 1'b1;
        end
        default: begin
          phase_next       = PH_IDLE;
          delay_count_next = '0;
        end
      endcase
    end

    if (load_byte) begin
      shift_byte_next = pick_byte(sel_idx, is_read, dev_addr, held_register, held_data);
      bit_count_next  = 4'd0;
      do_enter        = 1'b1;
      target          = PH_B_DATA;
    end

    if (do_enter) begin
      phase_next       = target;
      delay_count_next = hold_ticks(target, tpu);
      case (target)
        PH_S_SDA: begin
          line_oe_next  = 1'b1;
          line_sda_next = 1'b1;
        end
        PH_S_SCL:   line_scl_next = 1'b1;
        PH_S_FALL:  line_sda_next = 1'b0;
        PH_S_CLAMP: line_scl_next = 1'b0;
        PH_B_DATA: begin
          line_oe_next  = 1'b1;
          line_scl_next = 1'b0;
          line_sda_next = shift_byte_next[7];
        end
        PH_B_HIGH:  line_scl_next = 1'b1;
        PH_B_LOW:   line_scl_next = 1'b0;
        PH_A_REL: begin
          line_oe_next  = 1'b0;
          line_sda_next = 1'b1;
        end
        PH_A_HIGH:  line_scl_next = 1'b1;
        PH_A_LOW:   line_scl_next = 1'b0;
        PH_R_LOW: begin
          line_oe_next  = 1'b0;
          line_scl_next = 1'b0;
        end
        PH_R_HIGH:  line_scl_next = 1'b1;
        PH_N_SET: begin
          line_scl_next = 1'b0;
          line_oe_next  = 1'b1;
          line_sda_next = 1'b1;
        end
        PH_N_HIGH:  line_scl_next = 1'b1;
        PH_N_LOW:   line_scl_next = 1'b0;
        PH_P_LOW: begin
          line_oe_next  = 1'b1;
          line_scl_next = 1'b0;
          line_sda_next = 1'b0;
        end
        PH_P_SCL:   line_scl_next = 1'b1;
        PH_P_SDA:   line_sda_next = 1'b1;
        default: begin
          line_scl_next = line_scl;
        end
      endcase
    end

    result.scl_level        = line_scl_next;
    result.sda_level        = line_oe_next ? line_sda_next : 1'b1;
    result.sda_drive_enable = line_oe_next;
    result.busy_res         = (phase_next != PH_IDLE);
    result.done_res         = done;
    result.read_byte        = received_byte_next;
    result.ack_failed       = fail_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      is_read       <= 1'b0;
      byte_index    <= 3'd0;
      bit_count     <= 4'd0;
      shift_byte    <= 8'd0;
      held_register <= 8'd0;
      held_data     <= 8'd0;
      delay_count   <= '0;
      poll_count    <= 8'd0;
      received_byte <= 8'd0;
      fail_flag     <= 1'b0;
      line_scl      <= 1'b1;
      line_sda      <= 1'b1;
      line_oe       <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      is_read       <= is_read_next;
      byte_index    <= byte_index_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
      delay_count   <= delay_count_next;
      poll_count    <= poll_count_next;
      received_byte <= received_byte_next;
      fail_flag     <= fail_flag_next;
      line_scl      <= line_scl_next;
      line_sda      <= line_sda_next;
      line_oe       <= line_oe_next;
    end
  end

endmodule

// File: hw/rtl/i2c_register_transaction_master_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_transaction_master_core
// Tick-driven I2C master for single-register write and read transactions.
// ----------------------------------------------------------------------------
// Every request is one bus tick and yields exactly one result with the line
// levels and status after that tick. A request is registered on entry, runs
// through the sequencer's next-state logic and lands in the result register,
// so one request is taken per cycle unless a held result is stalled; the
// result register decouples the two sides. Line hold times are the phase's
// microsecond count (0, 1, 2 or 4) times ticks_per_microsecond, counted in
// ticks, with a zero hold lasting one tick. Configuration writes are
// always ready; a new tick rate applies from the next line change and a new
// device address from the next address byte loaded.
module i2c_register_transaction_master_core #(
  parameter int ACK_POLL_LIMIT = 250
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2crm_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2crm_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import i2crm_pkg::*;

  logic        s1_valid;
  in_item_t    s1_item;
  logic        res_valid;
  out_item_t   res_data;
  logic        advance;
  out_item_t   seq_result;
  logic [7:0]  dev_addr;
  logic [15:0] tpu;

  assign advance   = s1_valid && (!res_valid || !out_stall);
  assign in_stall  = s1_valid && res_valid && out_stall;
  assign out_valid = res_valid;
  assign out_data  = res_data;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEVICE_ADDRESS_RESET;
      tpu      <= TICKS_PER_US_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_addr <= cfg_data[7:0];
        CFG_TICKS_PER_US:   tpu      <= cfg_data;
        default:            dev_addr <= dev_addr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= seq_result;
    end
  end

  i2crm_seq #(
    .ACK_POLL_LIMIT(ACK_POLL_LIMIT)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (s1_item),
    .dev_addr(dev_addr),
    .tpu     (tpu),
    .result  (seq_result)
  );

endmodule

// File: hw/rtl/i2crm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_checker
// Port-level checks of the I2C register transaction master.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2crm_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input i2crm_pkg::out_item_t  out_data
);
  import i2crm_pkg::*;

  // a stalled result stays put
  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // the tick that ends a transaction already reports idle
  `CHK_NEVER(a_done_idle, clk, rst, out_valid && out_data.done_res && out_data.busy_res, "done while still busy")

  // a released data line reads as high
  `CHK_NEVER(a_release_high, clk, rst, out_valid && !out_data.sda_drive_enable && !out_data.sda_level, "released sda shown low")

  // idle bus: both lines high and driven
  `CHK_ASSERT(a_idle_bus, clk, rst, out_valid && !out_data.busy_res |-> out_data.scl_level && out_data.sda_level && out_data.sda_drive_enable, "bus not idle outside a transaction")

endmodule

bind i2c_register_transaction_master_core i2crm_checker u_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C register transaction master. Every bus tick
// is a request; a bus model in the bench works out the line levels and status
// each tick should give and checks every result against it or the table. A short table of
// ticks comes first, then random write and read transactions against a slave
// that acknowledges, acknowledges late or never, over several tick rates.
// ----------------------------------------------------------------------------
module tb_top;
  import i2crm_pkg::*;

  localparam logic [1:0]  KIND_SPARE      = 2'd3;
  localparam logic [1:0]  CFG_SPARE_INDEX = 2'd3;
  localparam logic [7:0]  DEV_AT_RESET    = 8'h80;
  localparam logic [15:0] TPU_AT_RESET    = 16'd72;
  localparam logic [7:0]  RD_FLAG         = 8'h01;
  localparam int          ACK_LIMIT       = 250;
  localparam int          SQUEEZE_AT      = 400;
  localparam int          SQUEEZE_LEN     = 64;
  localparam int          RUN_LIMIT_NS    = 10_000_000;

  localparam out_item_t LINES_IDLE  = {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam out_item_t LINES_START = {1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

  typedef enum logic [1:0] {SLAVE_ACKS, SLAVE_NEVER_ACKS, SLAVE_ACKS_LATE} slave_reply_t;
  typedef enum logic [1:0] {GAPS_SRC_LIGHT, GAPS_SNK_LIGHT, GAPS_NONE} gap_mode_t;

  typedef struct packed {
    in_item_t  req;
    logic      known;
    out_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  i2c_register_transaction_master_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // bus model state
  phase_t      m_phase;
  logic        m_is_read;
  logic [2:0]  m_byte_idx;
  logic [3:0]  m_bit_cnt;
  logic [7:0]  m_shift, m_reg, m_data, m_rx, m_polls;
  logic [23:0] m_hold;
  logic        m_failed, m_scl, m_sda, m_oe;
  logic [7:0]  m_dev;
  logic [15:0] m_tpu;

  out_item_t    expected_lines[$];
  stim_row_t    directed[$];
  slave_reply_t ack_plan[0:7];
  int           mismatches = 0;
  int           results_seen = 0;
  int           src_gap_pct = 0;
  int           snk_gap_pct = 0;
  int           squeeze_left = 0;
  bit           squeeze_done = 0;
  int           idle_gap = 0;
  bit           read_owed = 0;

  function automatic void reset_model();
    m_phase = PH_IDLE;
    m_is_read = 1'b0;
    m_byte_idx = '0;
    m_bit_cnt = '0;
    m_shift = '0;
    m_reg = '0;
    m_data = '0;
    m_hold = '0;
    m_polls = '0;
    m_rx = '0;
    m_failed = 1'b0;
    m_scl = 1'b1;
    m_sda = 1'b1;
    m_oe = 1'b1;
    m_dev = DEV_AT_RESET;
    m_tpu = TPU_AT_RESET;
    foreach (ack_plan[i]) ack_plan[i] = SLAVE_ACKS;
  endfunction

  // set the line levels of a phase and load its hold time
  function automatic void enter_phase(phase_t p);
    logic [2:0]  u;
    logic [23:0] c;
    u = 3'd0;
    m_phase = p;
    case (p)
      PH_S_SDA:   begin m_oe = 1'b1; m_sda = 1'b1; end
      PH_S_SCL:   begin m_scl = 1'b1; u = 3'd4; end
      PH_S_FALL:  begin m_sda = 1'b0; u = 3'd4; end
      PH_S_CLAMP: m_scl = 1'b0;
      PH_B_DATA:  begin m_oe = 1'b1; m_scl = 1'b0; m_sda = m_shift[7]; u = 3'd2; end
      PH_B_HIGH:  begin m_scl = 1'b1; u = 3'd2; end
      PH_B_LOW:   begin m_scl = 1'b0; u = 3'd2; end
      PH_A_REL:   begin m_oe = 1'b0; m_sda = 1'b1; u = 3'd1; end
      PH_A_HIGH:  begin m_scl = 1'b1; u = 3'd1; end
      PH_A_LOW:   m_scl = 1'b0;
      PH_R_LOW:   begin m_oe = 1'b0; m_scl = 1'b0; u = 3'd2; end
      PH_R_HIGH:  begin m_scl = 1'b1; u = 3'd1; end
      PH_N_SET:   begin m_scl = 1'b0; m_oe = 1'b1; m_sda = 1'b1; u = 3'd2; end
      PH_N_HIGH:  begin m_scl = 1'b1; u = 3'd2; end
      PH_N_LOW:   m_scl = 1'b0;
      PH_P_LOW:   begin m_oe = 1'b1; m_scl = 1'b0; m_sda = 1'b0; u = 3'd4; end
      PH_P_SCL:   m_scl = 1'b1;
      PH_P_SDA:   begin m_sda = 1'b1; u = 3'd4; end
      default: ;
    endcase
    c = u * m_tpu;
    // a zero hold still lasts one tick
    m_hold = (c == 24'd0) ? 24'd1 : c;
  endfunction

  function automatic void load_next_byte();
    if (m_byte_idx == 3'd0) m_shift = m_dev;
    else if (m_byte_idx == 3'd1) m_shift = m_reg;
    else if (m_is_read) m_shift = m_dev | RD_FLAG;
    else m_shift = m_data;
    m_bit_cnt = '0;
    enter_phase(PH_B_DATA);
  endfunction

  function automatic void after_ack();
    m_byte_idx = m_byte_idx + 3'd1;
    if (!m_is_read) begin
      if (m_byte_idx < 3'd3) load_next_byte();
      else enter_phase(PH_P_LOW);
    end else if (m_byte_idx == 3'd1) begin
      load_next_byte();
    end else if (m_byte_idx == 3'd2) begin
      // repeated start before the read address
      enter_phase(PH_S_SDA);
    end else begin
      m_bit_cnt = '0;
      m_shift = '0;
      enter_phase(PH_R_LOW);
    end
  endfunction

  function automatic logic advance_phase(logic sda);
    logic fin;
    fin = 1'b0;
    case (m_phase)
      PH_S_SDA:   enter_phase(PH_S_SCL);
      PH_S_SCL:   enter_phase(PH_S_FALL);
      PH_S_FALL:  enter_phase(PH_S_CLAMP);
      PH_S_CLAMP: load_next_byte();
      PH_B_DATA:  enter_phase(PH_B_HIGH);
      PH_B_HIGH:  enter_phase(PH_B_LOW);
      PH_B_LOW: begin
        m_bit_cnt = m_bit_cnt + 4'd1;
        if (m_bit_cnt >= 4'd8) begin
          m_polls = '0;
          enter_phase(PH_A_REL);
        end else begin
          m_shift = m_shift << 1;
          enter_phase(PH_B_DATA);
        end
      end
      PH_A_REL:   enter_phase(PH_A_HIGH);
      PH_A_HIGH: begin
        if (!sda) begin
          enter_phase(PH_A_LOW);
        end else if (m_polls >= ACK_LIMIT) begin
          m_failed = 1'b1;
          enter_phase(PH_P_LOW);
        end else begin
          m_polls = m_polls + 8'd1;
        end
      end
      PH_A_LOW:   after_ack();
      PH_R_LOW: begin
        m_shift = {m_shift[6:0], sda};
        enter_phase(PH_R_HIGH);
      end
      PH_R_HIGH: begin
        m_bit_cnt = m_bit_cnt + 4'd1;
        if (m_bit_cnt >= 4'd8) begin
          m_rx = m_shift;
          enter_phase(PH_N_SET);
        end else begin
          enter_phase(PH_R_LOW);
        end
      end
      PH_N_SET:   enter_phase(PH_N_HIGH);
      PH_N_HIGH:  enter_phase(PH_N_LOW);
      PH_N_LOW:   enter_phase(PH_P_LOW);
      PH_P_LOW:   enter_phase(PH_P_SCL);
      PH_P_SCL:   enter_phase(PH_P_SDA);
      PH_P_SDA: begin
        m_phase = PH_IDLE;
        m_hold = '0;
        fin = 1'b1;
      end
      default: begin
        m_phase = PH_IDLE;
        m_hold = '0;
      end
    endcase
    return fin;
  endfunction

  // one bus tick: returns the lines and status the block should show after it
  function automatic out_item_t predict_tick(in_item_t req);
    logic      fin;
    out_item_t o;
    fin = 1'b0;
    if (m_phase == PH_IDLE) begin
      if (req.kind == KIND_WRITE || req.kind == KIND_READ) begin
        m_is_read = (req.kind == KIND_READ);
        m_reg = req.register_address;
        m_data = req.write_byte;
        m_byte_idx = '0;
        m_bit_cnt = '0;
        m_shift = '0;
        m_polls = '0;
        m_failed = 1'b0;
        enter_phase(PH_S_SDA);
      end
    end else if (m_hold > 24'd1) begin
      m_hold = m_hold - 24'd1;
    end else begin
      fin = advance_phase(req.sda_sample);
    end
    o.scl_level = m_scl;
    o.sda_level = m_oe ? m_sda : 1'b1;
    o.sda_drive_enable = m_oe;
    o.busy_res = (m_phase != PH_IDLE);
    o.done_res = fin;
    o.read_byte = m_rx;
    o.ack_failed = m_failed;
    return o;
  endfunction

  // next tick from the host side plus the slave's answer on sda
  function automatic in_item_t next_request();
    in_item_t r;
    r.register_address = 8'($urandom);
    r.write_byte = 8'($urandom);
    r.sda_sample = 1'($urandom);
    r.kind = KIND_TICK;
    if (m_phase == PH_IDLE) begin
      if (idle_gap > 0) begin
        idle_gap--;
        if ($urandom_range(7) == 0) r.kind = KIND_SPARE;
      end else begin
        r.kind = (read_owed || $urandom_range(1) == 1) ? KIND_READ : KIND_WRITE;
        read_owed = 0;
        idle_gap = $urandom_range(5);
        foreach (ack_plan[i]) ack_plan[i] = SLAVE_ACKS;
        if ($urandom_range(4) == 0)
          ack_plan[$urandom_range(2)] =
            ($urandom_range(1) == 1) ? SLAVE_NEVER_ACKS : SLAVE_ACKS_LATE;
      end
    end else begin
      // stray commands while busy
      if ($urandom_range(15) == 0) r.kind = 2'($urandom);
      if (m_phase == PH_A_HIGH) begin
        case (ack_plan[m_byte_idx])
          SLAVE_NEVER_ACKS: r.sda_sample = 1'b1;
          SLAVE_ACKS_LATE:  r.sda_sample = (m_polls < ACK_LIMIT);
          default:          r.sda_sample = ($urandom_range(3) == 0);
        endcase
      end
    end
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic [1:0] kind, logic [7:0] ra, logic [7:0] wb,
                                         logic sda, logic known, out_item_t want);
    stim_row_t s;
    s.req.kind = kind;
    s.req.register_address = ra;
    s.req.write_byte = wb;
    s.req.sda_sample = sda;
    s.known = known;
    s.want = want;
    return s;
  endfunction

  task automatic set_gaps(input gap_mode_t g);
    case (g)
      GAPS_SRC_LIGHT: begin src_gap_pct = 15; snk_gap_pct = 79; end
      GAPS_SNK_LIGHT: begin src_gap_pct = 79; snk_gap_pct = 15; end
      default:        begin src_gap_pct = 0;  snk_gap_pct = 0;  end
    endcase
  endtask

  task automatic send_tick(input in_item_t req, input logic known, input out_item_t want);
    out_item_t mdl;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    mdl = predict_tick(req);
    expected_lines.push_back(known ? want : mdl);
    @(negedge clk);
  endtask

  task automatic run_traffic(input int budget, input bit to_idle);
    int n;
    n = 0;
    while (n < budget || (to_idle && (m_phase != PH_IDLE || read_owed))) begin
      send_tick(next_request(), 1'b0, LINES_IDLE);
      n++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_lines.size() != 0);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEVICE_ADDRESS: m_dev = val[7:0];
      CFG_TICKS_PER_US:   m_tpu = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic run_phase(input gap_mode_t g, input logic [7:0] addr, input logic [15:0] tpu,
                           input int budget, input bit to_idle);
    settle();
    set_gaps(g);
    write_register(CFG_DEVICE_ADDRESS, {8'($urandom), addr});
    write_register(CFG_TICKS_PER_US, tpu);
    // unused index, must leave both registers alone
    write_register(CFG_SPARE_INDEX, 16'($urandom));
    cfg_valid <= 1'b0;
    run_traffic(budget, to_idle);
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      squeeze_left = SQUEEZE_LEN;
      squeeze_done = 1;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_gap_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no request pending: %h", $realtime, out_data);
        mismatches++;
      end else begin
        want = expected_lines.pop_front();
        if (out_data !== want) begin
          if (mismatches < 10)
            $display({"%0t: result %0d exp/act scl %b/%b sda %b/%b oe %b/%b busy %b/%b",
                      " done %b/%b rd %h/%h fail %b/%b"}, $realtime, results_seen,
                     want.scl_level, out_data.scl_level, want.sda_level, out_data.sda_level,
                     want.sda_drive_enable, out_data.sda_drive_enable,
                     want.busy_res, out_data.busy_res, want.done_res, out_data.done_res,
                     want.read_byte, out_data.read_byte,
                     want.ack_failed, out_data.ack_failed);
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin
    reset_model();
    set_gaps(GAPS_SRC_LIGHT);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle bus with field extremes, then a write, then commands while busy
    directed.push_back(stim_row(KIND_TICK,  8'h00, 8'h00, 1'b0, 1'b1, LINES_IDLE));
    directed.push_back(stim_row(KIND_TICK,  8'hFF, 8'hFF, 1'b1, 1'b1, LINES_IDLE));
    directed.push_back(stim_row(KIND_SPARE, 8'h5A, 8'hA5, 1'b1, 1'b1, LINES_IDLE));
    directed.push_back(stim_row(KIND_TICK,  8'h00, 8'hFF, 1'b0, 1'b1, LINES_IDLE));
    directed.push_back(stim_row(KIND_TICK,  8'hFF, 8'h00, 1'b1, 1'b1, LINES_IDLE));
    directed.push_back(stim_row(KIND_WRITE, 8'hFF, 8'h00, 1'b1, 1'b1, LINES_START));
    directed.push_back(stim_row(KIND_TICK,  8'h00, 8'h00, 1'b0, 1'b0, '0));
    directed.push_back(stim_row(KIND_READ,  8'h00, 8'hFF, 1'b1, 1'b0, '0));
    directed.push_back(stim_row(KIND_WRITE, 8'h5A, 8'h5A, 1'b0, 1'b0, '0));
    directed.push_back(stim_row(KIND_SPARE, 8'hFF, 8'hFF, 1'b1, 1'b0, '0));
    directed.push_back(stim_row(KIND_TICK,  8'h81, 8'h7E, 1'b0, 1'b0, '0));
    directed.push_back(stim_row(KIND_TICK,  8'h7E, 8'h81, 1'b1, 1'b0, '0));
    directed.push_back(stim_row(KIND_READ,  8'hFF, 8'h00, 1'b0, 1'b0, '0));
    directed.push_back(stim_row(KIND_TICK,  8'h00, 8'h00, 1'b1, 1'b0, '0));
    foreach (directed[i]) send_tick(directed[i].req, directed[i].known, directed[i].want);

    // the start hold already loaded runs out at the reset tick rate, then
    // the write and one read finish at the zero tick rate
    settle();
    write_register(CFG_TICKS_PER_US, 16'd0);
    cfg_valid <= 1'b0;
    read_owed = 1;
    run_traffic(1, 1'b1);

    run_phase(GAPS_SRC_LIGHT, 8'h00, 16'd1, 60, 1'b1);
    run_phase(GAPS_SNK_LIGHT, 8'hFF, 16'd0, 60, 1'b1);
    run_phase(GAPS_NONE, 8'($urandom), 16'd1, 60, 1'b1);

    // widest tick rate: start a transfer and stop inside its first long hold
    idle_gap = 0;
    run_phase(GAPS_NONE, 8'hA6, 16'hFFFF, 40, 1'b0);

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
